// ===== sv/sorted_list_table_core_macros.svh =====
// assertion helpers for the sorted list table
`ifndef SORTED_LIST_TABLE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define SLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorted list table check failed");

// checked on every clock edge, reset included
`define SLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sorted list table check failed");

`endif

// ===== sv/slt_pkg.sv =====
// ---------------------------------------------------------------------------
// slt_pkg
// shared constants and types of the sorted list table
// ---------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int CAPACITY   = 32;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int MODE_W     = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 3'd4;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // command broadcast to every cell
  typedef struct packed {
    logic  ins;
    logic  del;
    item_t val;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/slt_cell.sv =====
// ---------------------------------------------------------------------------
// slt_cell
// one table slot: compares against the key and shifts with its neighbors
// ---------------------------------------------------------------------------
`default_nettype none

module slt_cell
  import slt_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_cmd_t cmd,
  input  wire logic      occ,
  input  wire logic      left_lt,
  input  wire item_t     left_ent,
  input  wire item_t     right_ent,
  output item_t          ent,
  output logic           lt,
  output logic           eq
);

  item_t ent_r;
  item_t ent_nxt;

  assign ent = ent_r;
  assign lt  = occ && (ent_r < cmd.val);
  assign eq  = occ && (ent_r == cmd.val);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && !lt) begin
      // first slot not below the key takes it, later slots move right
      ent_nxt = left_lt ? cmd.val : left_ent;
    end else if (cmd.del && !lt) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/slt_row.sv =====
// ---------------------------------------------------------------------------
// slt_row
// row of table cells with match reduction and cursor read
// ---------------------------------------------------------------------------
`default_nettype none

module slt_row
  import slt_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire cnt_t             cnt,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic                  hit,
  output item_t                 rd_data
);

  item_t ent [CAPACITY];
  logic  lt  [CAPACITY];
  logic  eq  [CAPACITY];
  logic [CAPACITY-1:0] match;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  occ_i;
    logic  left_lt_i;
    item_t left_i;
    item_t right_i;

    assign occ_i = (cnt_t'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_lt_i = 1'b1;
      assign left_i    = cmd.val;
    end else begin : g_mid
      assign left_lt_i = lt[i-1];
      assign left_i    = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_i = ent[i];
    end else begin : g_inner
      assign right_i = ent[i+1];
    end

    // first equal slot sits where the less-than prefix ends
    assign match[i] = left_lt_i && eq[i];

    slt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ_i),
      .left_lt   (left_lt_i),
      .left_ent  (left_i),
      .right_ent (right_i),
      .ent       (ent[i]),
      .lt        (lt[i]),
      .eq        (eq[i])
    );
  end

  assign hit     = |match;
  assign rd_data = ent[rd_idx];

endmodule

`default_nettype wire

// ===== sv/sorted_list_table_core.sv =====
// an accepted input beat is captured and moves the core to its execute state, where the
// cell row acts on it and the result beat is registered; no new input beat is taken until then
// a stalled result holds the execute state until the output register frees up
// reset (rst_n low, synchronous) empties the table, parks the cursor before the
// first entry and drops out_valid; cell contents are not cleared
// ---------------------------------------------------------------------------
// sorted_list_table_core
// ascending table of items kept in a row of shifting compare cells
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_list_table_core_macros.svh"

module sorted_list_table_core
  import slt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input beats
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire item_t             in_item_value,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output item_t                  out_item_out,
  output cnt_t                   out_item_count,
  output logic                   out_is_full,
  output logic                   out_error
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // control state
  logic st_r, st_nxt;
  cnt_t cnt_r, cnt_nxt;
  cnt_t cur_r, cur_nxt;
  logic out_valid_r, out_valid_nxt;

  // captured operation (payload)
  logic [MODE_W-1:0] mode_r;
  item_t             val_r;

  // result register (payload)
  logic  found_r, found_nxt;
  item_t item_r, item_nxt;
  cnt_t  ocnt_r, ocnt_nxt;
  logic  full_r, full_nxt;
  logic  err_r, err_nxt;

  cell_cmd_t cmd;
  logic      hit;
  item_t     rd_data;
  logic      fire;
  logic      is_full;

  // input is taken whenever no operation is pending in the row
  assign in_ready = (st_r == ST_IDLE);
  // execute only when the result slot is free or being drained
  assign fire     = (st_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign is_full  = (cnt_r == cnt_t'(CAPACITY));

  slt_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .cnt     (cnt_r),
    .rd_idx  (cur_r[IDX_W-1:0]),
    .hit     (hit),
    .rd_data (rd_data)
  );

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    item_nxt      = item_r;
    ocnt_nxt      = ocnt_r;
    full_nxt      = full_r;
    err_nxt       = err_r;
    cmd.ins       = 1'b0;
    cmd.del       = 1'b0;
    cmd.val       = val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_valid && in_ready) begin
      st_nxt = ST_EXEC;
    end

    if (fire) begin
      found_nxt = 1'b0;
      item_nxt  = '0;
      err_nxt   = 1'b0;
      case (mode_r)
        MODE_INSERT: begin
          if (is_full) begin
            err_nxt = 1'b1;
          end else begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
        MODE_DELETE: begin
          if (hit) begin
            cmd.del = 1'b1;
            cnt_nxt = cnt_r - cnt_t'(1);
          end else begin
            err_nxt = 1'b1;
          end
        end
        MODE_FIND: begin
          // a match returns the key itself
          found_nxt = hit;
          item_nxt  = hit ? val_r : '0;
        end
        MODE_RESTART: begin
          cur_nxt = '0;
        end
        MODE_NEXT: begin
          if (cur_r < cnt_r) begin
            found_nxt = 1'b1;
            item_nxt  = rd_data;
            cur_nxt   = cur_r + cnt_t'(1);
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          // unused modes leave the table alone
        end
      endcase
      ocnt_nxt      = cnt_nxt;
      full_nxt      = (cnt_nxt == cnt_t'(CAPACITY));
      out_valid_nxt = 1'b1;
      st_nxt        = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      val_r  <= in_item_value;
    end
    found_r <= found_nxt;
    item_r  <= item_nxt;
    ocnt_r  <= ocnt_nxt;
    full_r  <= full_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_item_out   = item_r;
  assign out_item_count = ocnt_r;
  assign out_is_full    = full_r;
  assign out_error      = err_r;

  // table never holds more than its capacity
  `SLT_ASSERT(a_cnt_bound, cnt_r <= cnt_t'(CAPACITY))
  // count moves by at most one per operation
  `SLT_ASSERT(a_cnt_step, ##1 (cnt_r - $past(cnt_r) + cnt_t'(1) <= cnt_t'(2)))
  // a blocked execute cycle waits in place
  `SLT_ASSERT(a_exec_hold, (st_r == ST_EXEC && !fire) |=> (st_r == ST_EXEC))
  // a result beat never reports both a hit and an error
  `SLT_ASSERT(a_found_err, out_valid_r |-> !(found_r && err_r))

endmodule

`default_nettype wire
